>>> sv/dshmm_pkg.sv
package dshmm_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned TEMP_W = 12;
  localparam int unsigned HUM_W  = 10;
  localparam int unsigned CNT_W  = 8;

  typedef struct packed {
    logic        [TIME_W-1:0] sample_time;
    logic signed [TEMP_W-1:0] sample_temp;
    logic        [HUM_W-1:0]  sample_hum;
  } in_item_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] min_temp;
    logic signed [TEMP_W-1:0] max_temp;
    logic        [HUM_W-1:0]  min_hum;
    logic        [HUM_W-1:0]  max_hum;
    logic        [CNT_W-1:0]  history_count;
    logic                     point_made;
    logic        [TIME_W-1:0] point_time;
    logic signed [TEMP_W-1:0] point_temp;
    logic        [HUM_W-1:0]  point_hum;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic sum_run;
    logic div_init;
    logic div_step;
    logic push;
    logic grp_write;
    logic scan_run;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic group_full;
    logic sum_done;
    logic scan_done;
  } sts_t;

endpackage

>>> sv/dshmm_ram.sv
module dshmm_ram #(
  parameter int unsigned WIDTH = 22,
  parameter int unsigned DEPTH = 240
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/dshmm_ctrl.sv
module dshmm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  dshmm_pkg::sts_t sts_i,
  output dshmm_pkg::cmd_t cmd_o
);
  import dshmm_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SUM   = 3'd1;
  localparam logic [2:0] ST_PREP  = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_PUSH  = 3'd4;
  localparam logic [2:0] ST_WRITE = 3'd5;
  localparam logic [2:0] ST_SCAN  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.group_full ? ST_SUM : ST_WRITE;
        end
      end
      ST_SUM: begin
        cmd_o.sum_run = 1'b1;
        if (sts_i.sum_done) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        state_d        = ST_PUSH;
      end
      ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.grp_write = 1'b1;
        state_d         = ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE)
    else $error("accepted item did not start work");

  a_push_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_PUSH |-> $past(state_q) == ST_DIV)
    else $error("point pushed without a finished division");

  a_result_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_DONE)
    else $error("result offered before the scan finished");
`endif

endmodule

>>> sv/dshmm_dp.sv
module dshmm_dp #(
  parameter int unsigned GROUP   = 6,
  parameter int unsigned HISTORY = 240
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  dshmm_pkg::in_item_t  in_data_i,
  input  dshmm_pkg::cmd_t      cmd_i,
  output dshmm_pkg::sts_t      sts_o,
  output dshmm_pkg::out_item_t out_data_o
);
  import dshmm_pkg::*;

  localparam int unsigned GA_W     = (GROUP > 1) ? $clog2(GROUP) : 1;
  localparam int unsigned GF_W     = $clog2(GROUP + 1);
  localparam int unsigned HA_W     = (HISTORY > 1) ? $clog2(HISTORY) : 1;
  localparam int unsigned HF_W     = $clog2(HISTORY + 1);
  localparam int unsigned SCAN_MAX = (GROUP > HISTORY) ? GROUP : HISTORY;
  localparam int unsigned IX_W     = $clog2(SCAN_MAX + 1);
  localparam int unsigned SUM_W    = TEMP_W + $clog2(GROUP);
  localparam int unsigned DIV_W    = SUM_W + 1;
  localparam int unsigned RS       = DIV_W + $clog2(GROUP);
  localparam int unsigned RCP_W    = RS + 1;
  localparam int unsigned PRD_W    = DIV_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP =
    RCP_W'(((64'd1 << RS) + 64'(GROUP) - 64'd1) / 64'(GROUP));
  localparam int unsigned ENT_W    = TEMP_W + HUM_W;

  in_item_t                 smp_q;
  logic        [GF_W-1:0]   gfill_q;
  logic        [TIME_W-1:0] gtime_q;
  logic        [HA_W-1:0]   wptr_q;
  logic        [HF_W-1:0]   hfill_q;
  logic        [IX_W-1:0]   idx_q;
  logic                     grv_q, hrv_q;
  logic signed [SUM_W-1:0]  tsum_q;
  logic        [SUM_W-1:0]  hsum_q;
  logic                     tneg_q;
  logic        [DIV_W-1:0]  tdvd_q, hdvd_q;
  logic                     made_q;
  logic        [TIME_W-1:0] ptime_q;
  logic signed [TEMP_W-1:0] ptemp_q;
  logic        [HUM_W-1:0]  phum_q;
  logic signed [TEMP_W-1:0] mint_q, maxt_q;
  logic        [HUM_W-1:0]  minh_q, maxh_q;
  out_item_t                out_q;

  logic                     g_re, h_re, scan_more;
  logic        [ENT_W-1:0]  g_rdata, h_rdata, g_wdata, h_wdata;
  logic signed [TEMP_W-1:0] g_rt, h_rt;
  logic        [HUM_W-1:0]  g_rh, h_rh;
  logic signed [DIV_W-1:0]  tsum_x, tmag;
  logic        [PRD_W-1:0]  tprod, hprod;
  logic signed [TEMP_W-1:0] pt_val;
  logic        [HUM_W-1:0]  ph_val;
  logic signed [TEMP_W-1:0] mint_d, maxt_d;
  logic        [HUM_W-1:0]  minh_d, maxh_d;

  assign scan_more = (idx_q < IX_W'(gfill_q)) || (idx_q < IX_W'(hfill_q));
  assign g_re = (cmd_i.sum_run && (idx_q < IX_W'(GROUP)))
             || (cmd_i.scan_run && (idx_q < IX_W'(gfill_q)));
  assign h_re = cmd_i.scan_run && (idx_q < IX_W'(hfill_q));

  assign g_wdata = {smp_q.sample_temp, smp_q.sample_hum};
  assign h_wdata = {pt_val, ph_val};

  dshmm_ram #(.WIDTH(ENT_W), .DEPTH(GROUP)) u_grp_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.grp_write),
    .waddr_i (gfill_q[GA_W-1:0]),
    .wdata_i (g_wdata),
    .re_i    (g_re),
    .raddr_i (idx_q[GA_W-1:0]),
    .rdata_o (g_rdata)
  );

  dshmm_ram #(.WIDTH(ENT_W), .DEPTH(HISTORY)) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (wptr_q),
    .wdata_i (h_wdata),
    .re_i    (h_re),
    .raddr_i (idx_q[HA_W-1:0]),
    .rdata_o (h_rdata)
  );

  assign g_rt = signed'(g_rdata[ENT_W-1:HUM_W]);
  assign g_rh = g_rdata[HUM_W-1:0];
  assign h_rt = signed'(h_rdata[ENT_W-1:HUM_W]);
  assign h_rh = h_rdata[HUM_W-1:0];

  assign tsum_x = DIV_W'(tsum_q);
  assign tmag   = tsum_q[SUM_W-1] ? -tsum_x : tsum_x;

  assign tprod = PRD_W'(tdvd_q) * PRD_W'(RECIP);
  assign hprod = PRD_W'(hdvd_q) * PRD_W'(RECIP);

  assign pt_val = tneg_q ? -signed'(tdvd_q[TEMP_W-1:0]) : signed'(tdvd_q[TEMP_W-1:0]);
  assign ph_val = hdvd_q[HUM_W-1:0];

  always_comb begin
    mint_d = mint_q;
    maxt_d = maxt_q;
    minh_d = minh_q;
    maxh_d = maxh_q;
    if (grv_q) begin
      if (g_rt < mint_d) mint_d = g_rt;
      if (g_rt > maxt_d) maxt_d = g_rt;
      if (g_rh < minh_d) minh_d = g_rh;
      if (g_rh > maxh_d) maxh_d = g_rh;
    end
    if (hrv_q) begin
      if (h_rt < mint_d) mint_d = h_rt;
      if (h_rt > maxt_d) maxt_d = h_rt;
      if (h_rh < minh_d) minh_d = h_rh;
      if (h_rh > maxh_d) maxh_d = h_rh;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gfill_q <= '0;
      gtime_q <= '0;
      wptr_q  <= '0;
      hfill_q <= '0;
      idx_q   <= '0;
      grv_q   <= 1'b0;
      hrv_q   <= 1'b0;
      made_q  <= 1'b0;
    end else begin
      grv_q <= g_re;
      hrv_q <= h_re;
      if (cmd_i.load || cmd_i.grp_write) begin
        idx_q <= '0;
      end else if (g_re || h_re) begin
        idx_q <= idx_q + IX_W'(1);
      end
      if (cmd_i.load) begin
        made_q <= 1'b0;
      end
      if (cmd_i.push) begin
        made_q  <= 1'b1;
        gfill_q <= '0;
        wptr_q  <= (wptr_q == HA_W'(HISTORY - 1)) ? '0 : wptr_q + HA_W'(1);
        if (hfill_q != HF_W'(HISTORY)) begin
          hfill_q <= hfill_q + HF_W'(1);
        end
      end
      if (cmd_i.grp_write) begin
        gfill_q <= gfill_q + GF_W'(1);
        if (gfill_q == '0) begin
          gtime_q <= smp_q.sample_time;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      smp_q  <= in_data_i;
      tsum_q <= '0;
      hsum_q <= '0;
    end else if (cmd_i.sum_run && grv_q) begin
      tsum_q <= tsum_q + SUM_W'(g_rt);
      hsum_q <= hsum_q + SUM_W'(g_rh);
    end
    if (cmd_i.div_init) begin
      tneg_q <= tsum_q[SUM_W-1];
      tdvd_q <= unsigned'(tmag) + DIV_W'(GROUP / 2);
      hdvd_q <= DIV_W'(hsum_q) + DIV_W'(GROUP / 2);
    end else if (cmd_i.div_step) begin
      tdvd_q <= tprod[RS +: DIV_W];
      hdvd_q <= hprod[RS +: DIV_W];
    end
    if (cmd_i.push) begin
      ptime_q <= gtime_q;
      ptemp_q <= pt_val;
      phum_q  <= ph_val;
    end
    if (cmd_i.grp_write) begin
      mint_q <= smp_q.sample_temp;
      maxt_q <= smp_q.sample_temp;
      minh_q <= smp_q.sample_hum;
      maxh_q <= smp_q.sample_hum;
    end else if (cmd_i.scan_run) begin
      mint_q <= mint_d;
      maxt_q <= maxt_d;
      minh_q <= minh_d;
      maxh_q <= maxh_d;
    end
    if (cmd_i.emit) begin
      out_q.min_temp      <= mint_q;
      out_q.max_temp      <= maxt_q;
      out_q.min_hum       <= minh_q;
      out_q.max_hum       <= maxh_q;
      out_q.history_count <= CNT_W'(hfill_q);
      out_q.point_made    <= made_q;
      out_q.point_time    <= made_q ? ptime_q : '0;
      out_q.point_temp    <= made_q ? ptemp_q : '0;
      out_q.point_hum     <= made_q ? phum_q : '0;
    end
  end

  assign sts_o.group_full = (gfill_q == GF_W'(GROUP));
  assign sts_o.sum_done   = (idx_q == IX_W'(GROUP));
  assign sts_o.scan_done  = !scan_more;
  assign out_data_o       = out_q;

`ifndef SYNTH
  a_hist_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hfill_q <= HF_W'(HISTORY))
    else $error("history fill beyond depth");

  a_push_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> sts_o.group_full)
    else $error("point pushed from a group that is not full");

  a_write_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.grp_write |=> (gfill_q != '0) && (gfill_q <= GF_W'(GROUP)))
    else $error("group fill wrong after sample write");
`endif

endmodule

>>> sv/decimating_sensor_history_minmax.sv
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_ready_o   | in_data_i  (dshmm_pkg::in_item_t)
// out     | output    | out_valid_o / out_ready_i | out_data_o (dshmm_pkg::out_item_t)
//
// One item at a time; from accept to result register an item is loaded, then, when the
// group is full, the group is summed, the rounding offset added, the sum multiplied by
// the reciprocal and the point written to history; then the sample is written to the group
// store and a min/max scan runs over group and history through the two RAM read ports.
// Reset clears the fill counts and pointers; store contents need no clearing.
// A result waiting in the output register does not block accept; the next result
// holds in the controller until the output register is taken.
module decimating_sensor_history_minmax #(
  parameter int unsigned GROUP   = 6,
  parameter int unsigned HISTORY = 240
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  dshmm_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dshmm_pkg::out_item_t out_data_o
);
  import dshmm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  dshmm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dshmm_dp #(
    .GROUP   (GROUP),
    .HISTORY (HISTORY)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

>>> tb/decimating_sensor_history_minmax_tb.sv
module decimating_sensor_history_minmax_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dshmm_pkg::*;

  localparam int unsigned GROUP     = 6;
  localparam int unsigned HISTORY   = 240;
  localparam int unsigned HALF_CLK  = 4;
  localparam int unsigned LIMIT     = 8_000_000;
  localparam int unsigned BATCH_A   = 300;
  localparam int unsigned BATCH_B   = 475;
  localparam int unsigned WIDE_SPAN = 80;
  localparam int unsigned SETTLE    = 300;

  class minmax_scoreboard;
    logic signed [TEMP_W-1:0] grp_temp [GROUP];
    logic        [HUM_W-1:0]  grp_hum  [GROUP];
    logic        [TIME_W-1:0] grp_first_time = '0;
    int unsigned              grp_fill = 0;
    logic signed [TEMP_W-1:0] hist_temp [HISTORY];
    logic        [HUM_W-1:0]  hist_hum  [HISTORY];
    int unsigned              hist_head = 0;
    int unsigned              hist_fill = 0;
    out_item_t                expected_q[$];
    int unsigned              errors = 0;

    function int group_average(int sum);
      int mag;
      int q;
      mag = (sum < 0) ? -sum : sum;
      q   = (mag + GROUP / 2) / GROUP;
      return (sum < 0) ? -q : q;
    endfunction

    function void note_input(in_item_t s);
      out_item_t                r;
      int                       tsum;
      int                       hsum;
      int unsigned              slot;
      int unsigned              k;
      logic signed [TEMP_W-1:0] mn_t;
      logic signed [TEMP_W-1:0] mx_t;
      logic        [HUM_W-1:0]  mn_h;
      logic        [HUM_W-1:0]  mx_h;
      r = '0;
      if (grp_fill >= GROUP) begin
        tsum = 0;
        hsum = 0;
        for (int i = 0; i < GROUP; i++) begin
          tsum += int'(grp_temp[i]);
          hsum += int'(grp_hum[i]);
        end
        r.point_temp = TEMP_W'(group_average(tsum));
        r.point_hum  = HUM_W'(group_average(hsum));
        r.point_time = grp_first_time;
        r.point_made = 1'b1;
        if (hist_fill < HISTORY) begin
          slot = (hist_head + hist_fill) % HISTORY;
          hist_temp[slot] = r.point_temp;
          hist_hum[slot]  = r.point_hum;
          hist_fill++;
        end else begin
          hist_temp[hist_head] = r.point_temp;
          hist_hum[hist_head]  = r.point_hum;
          hist_head = (hist_head + 1) % HISTORY;
        end
        grp_fill = 0;
      end
      if (grp_fill == 0) grp_first_time = s.sample_time;
      grp_temp[grp_fill] = s.sample_temp;
      grp_hum[grp_fill]  = s.sample_hum;
      grp_fill++;

      mn_t = s.sample_temp;
      mx_t = s.sample_temp;
      mn_h = s.sample_hum;
      mx_h = s.sample_hum;
      for (int i = 0; i < grp_fill; i++) begin
        if (grp_temp[i] < mn_t) mn_t = grp_temp[i];
        if (grp_temp[i] > mx_t) mx_t = grp_temp[i];
        if (grp_hum[i] < mn_h) mn_h = grp_hum[i];
        if (grp_hum[i] > mx_h) mx_h = grp_hum[i];
      end
      for (int i = 0; i < hist_fill; i++) begin
        k = (hist_head + i) % HISTORY;
        if (hist_temp[k] < mn_t) mn_t = hist_temp[k];
        if (hist_temp[k] > mx_t) mx_t = hist_temp[k];
        if (hist_hum[k] < mn_h) mn_h = hist_hum[k];
        if (hist_hum[k] > mx_h) mx_h = hist_hum[k];
      end
      r.min_temp      = mn_t;
      r.max_temp      = mx_t;
      r.min_hum       = mn_h;
      r.max_hum       = mx_h;
      r.history_count = CNT_W'(hist_fill);
      expected_q.insert(expected_q.size(), r);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $error("result with no item pending");
        errors++;
        return;
      end
      want = expected_q[0];
      expected_q.delete(0);
      compare_field("min_temp", want.min_temp, got.min_temp);
      compare_field("max_temp", want.max_temp, got.max_temp);
      compare_field("min_hum", want.min_hum, got.min_hum);
      compare_field("max_hum", want.max_hum, got.max_hum);
      compare_field("history_count", want.history_count, got.history_count);
      compare_field("point_made", want.point_made, got.point_made);
      compare_field("point_time", want.point_time, got.point_time);
      compare_field("point_temp", want.point_temp, got.point_temp);
      compare_field("point_hum", want.point_hum, got.point_hum);
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data = '0;
  logic      out_valid_o;
  logic      out_ready = 1'b0;
  out_item_t out_data_o;

  minmax_scoreboard sb;
  int unsigned      cycles = 0;
  int unsigned      ready_hold = 0;
  logic [31:0]      cur_time = 32'd1000;
  int               temp_base = 220;
  int               hum_base = 500;
  in_item_t         samples_q[$];

  decimating_sensor_history_minmax #(
    .GROUP   (GROUP),
    .HISTORY (HISTORY)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o)
  );

  always #(HALF_CLK) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready) sb.check_result(out_data_o);
  end

  // hold each ready level for a while; the style rotates among three, chosen from the cycle counter
  always @(negedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold--;
    end else begin
      case ((cycles >> 12) % 3)
        0: begin
          out_ready <= 1'b1;
          ready_hold = 63;
        end
        1: begin
          out_ready <= 1'($urandom_range(0, 1));
          ready_hold = $urandom_range(0, 4);
        end
        default: begin
          out_ready <= ($urandom_range(0, 3) != 0);
          ready_hold = $urandom_range(0, 400);
        end
      endcase
    end
  end

  function automatic in_item_t mk_sample(logic [31:0] t, int temp, int hum);
    in_item_t s;
    s.sample_time = t;
    s.sample_temp = temp[TEMP_W-1:0];
    s.sample_hum  = hum[HUM_W-1:0];
    return s;
  endfunction

  function automatic void add_sample(in_item_t s);
    samples_q.insert(samples_q.size(), s);
  endfunction

  function automatic in_item_t random_sample(int unsigned idx);
    int temp;
    int hum;
    if ($urandom_range(0, 49) == 0) cur_time = $urandom;
    else cur_time += $urandom_range(1, 120);

    if (idx < WIDE_SPAN && $urandom_range(0, 99) < 15) begin
      temp = int'($urandom_range(0, 4095)) - 2048;
    end else if ($urandom_range(0, 99) < 4) begin
      temp = int'($urandom_range(0, 1650)) - 400;
    end else begin
      temp_base += int'($urandom_range(0, 6)) - 3;
      if (temp_base < 100) temp_base = 100;
      if (temp_base > 350) temp_base = 350;
      temp = temp_base;
    end

    if (idx < WIDE_SPAN && $urandom_range(0, 99) < 15) begin
      hum = $urandom_range(0, 1023);
    end else if ($urandom_range(0, 99) < 4) begin
      hum = $urandom_range(0, 1000);
    end else begin
      hum_base += int'($urandom_range(0, 10)) - 5;
      if (hum_base < 300) hum_base = 300;
      if (hum_base > 700) hum_base = 700;
      hum = hum_base;
    end
    return mk_sample(cur_time, temp, hum);
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic drive_samples(input in_item_t items[$]);
    int unsigned burst;
    int unsigned gap;
    burst = $urandom_range(1, 8);
    foreach (items[n]) begin
      in_data  <= items[n];
      in_valid <= 1'b1;
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
      sb.note_input(items[n]);
      @(negedge clk_i);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 8);
        gap   = $urandom_range(1, 300);
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    if (in_valid) in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    sb = new;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // extremes of the temperature and humidity fields
    add_sample(mk_sample(32'h0000_0000, -400, 0));
    add_sample(mk_sample(32'h0000_0001, 1250, 1000));
    add_sample(mk_sample(32'h0000_0002, -2048, 1023));
    add_sample(mk_sample(32'h0000_0003, 2047, 0));
    add_sample(mk_sample(32'h0000_0004, 0, 512));
    add_sample(mk_sample(32'h0000_0005, -1, 1));
    // positive half-way average, rounds up
    for (int i = 0; i < GROUP; i++)
      add_sample(mk_sample(32'hFFFF_FFFF - i, (i < 3) ? 1 : 0, (i < 3) ? 1 : 0));
    // negative half-way average, rounds away from zero
    for (int i = 0; i < GROUP; i++)
      add_sample(mk_sample(32'hAAAA_AAAA + i, (i < 3) ? -1 : 0,
                           (i % 2) ? 10'h155 : 10'h2AA));
    for (int i = 0; i < GROUP; i++)
      add_sample(mk_sample(32'h5555_5555 + i, int'($urandom_range(0, 4095)) - 2048,
                           $urandom_range(0, 1023)));
    add_sample(mk_sample(32'd1000, 300, 450));
    drive_samples(samples_q);
    drain_results();

    samples_q.delete();
    for (int unsigned i = 0; i < BATCH_A; i++) add_sample(random_sample(i));
    drive_samples(samples_q);
    drain_results();

    // resume after a full drain and keep the history growing
    samples_q.delete();
    for (int unsigned i = BATCH_A; i < BATCH_A + BATCH_B; i++)
      add_sample(random_sample(i));
    drive_samples(samples_q);
    drain_results();
    repeat (SETTLE) @(posedge clk_i);

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/dshmm_pkg.sv
sv/dshmm_ram.sv
sv/dshmm_ctrl.sv
sv/dshmm_dp.sv
sv/decimating_sensor_history_minmax.sv
tb/decimating_sensor_history_minmax_tb.sv
